[rtl/core/srrw_pkg.sv]
// ----------------------------------------------------------------------------
// srrw_pkg
// Types and codes shared by the selective-repeat receive window modules.
// ----------------------------------------------------------------------------
package srrw_pkg;

	// Verdict codes of a result.
	localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
	localparam logic [1:0] VERDICT_DUPLICATE = 2'd1;
	localparam logic [1:0] VERDICT_IGNORE    = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_WINDOW_BYTES = 1'b0;
	localparam logic CFG_FILE_BYTES   = 1'b1;

	// Width of the configuration write data.
	localparam int CFG_DATA_W = 32;

	// Reset value of the window size.
	localparam logic [16:0] WINDOW_RESET = 17'd1250;

	// One packet header.
	typedef struct packed {
		logic [31:0] seq_start;
		logic [7:0]  payload_len;
	} in_t;

	// One result.
	typedef struct packed {
		logic [1:0]  verdict;
		logic [15:0] buffer_offset;
		logic [7:0]  packet_offset;
		logic [7:0]  write_len;
		logic [31:0] ack_pos;
		logic [7:0]  ack_len;
		logic        flushed;
		logic [31:0] stream_base;
		logic        done_res;
	} out_t;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic valid;
		in_t  item;
	} queue_head_t;

	// Back end controls toward the front end.
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

endpackage

[rtl/core/srrw_ram.sv]
// ----------------------------------------------------------------------------
// srrw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module srrw_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/srrw_front.sv]
// ----------------------------------------------------------------------------
// srrw_front
// Accepts packet headers, saturates the length and queues them for the back end.
// ----------------------------------------------------------------------------
module srrw_front #(
	parameter int MAX_PAYLOAD = 250
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  srrw_pkg::in_t         in_data,
	input  srrw_pkg::back_ctl_t   ctl,
	output srrw_pkg::queue_head_t head
);

	srrw_pkg::in_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;
	srrw_pkg::in_t sat_item;

	// Length saturation at the payload maximum.
	always_comb begin
		sat_item = in_data;
		if (32'(in_data.payload_len) > 32'(MAX_PAYLOAD)) begin
			sat_item.payload_len = 8'(MAX_PAYLOAD);
		end
	end

	assign in_ready   = (count_q != 2'd2) && !ctl.clearing;
	assign push       = in_valid && in_ready;
	assign pop        = ctl.pop && (count_q != 2'd0);
	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= sat_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// The fill count never passes the queue depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue overfilled");
	// A pop is only requested when an entry is there.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> count_q != 2'd0) else $error("pop from empty queue");
	// No request enters while the map is being cleared.
	a_no_push_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clearing |-> !push) else $error("push during clearing");

endmodule

[rtl/core/srrw_back.sv]
// ----------------------------------------------------------------------------
// srrw_back
// Advances the base over the received map, clips a packet to the window,
// marks its bytes and delivers the result.
// ----------------------------------------------------------------------------
module srrw_back #(
	parameter int BUFFER_BYTES = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srrw_pkg::queue_head_t head,
	output srrw_pkg::back_ctl_t   ctl,
	input  logic [16:0]           window_bytes,
	input  logic [31:0]           file_bytes,
	output logic                  out_valid,
	input  logic                  out_ready,
	output srrw_pkg::out_t        out_data
);

	localparam int          ABITS = $clog2(BUFFER_BYTES);
	localparam logic [33:0] BUF34 = 34'(BUFFER_BYTES);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_ADVRD = 4'd2;
	localparam logic [3:0] ST_ADVCK = 4'd3;
	localparam logic [3:0] ST_C1    = 4'd4;
	localparam logic [3:0] ST_C2    = 4'd5;
	localparam logic [3:0] ST_C3    = 4'd6;
	localparam logic [3:0] ST_C4    = 4'd7;
	localparam logic [3:0] ST_RES   = 4'd8;
	localparam logic [3:0] ST_MARK  = 4'd9;

	logic [3:0]       state_q;
	logic [ABITS-1:0] clr_addr_q;
	logic             epoch_q;
	logic [ABITS:0]   base_q;
	logic [31:0]      origin_q;
	logic             flushed_q;
	logic [31:0]      seq_q;
	logic [7:0]       len_q;
	logic [31:0]      ws_q;
	logic [33:0]      wl_q;
	logic [33:0]      pstart_q;
	logic [33:0]      sum_q;
	logic [33:0]      wsend_q;
	logic [33:0]      pend_q;
	logic [33:0]      pswl_q;
	logic [ABITS-1:0] mark_addr_q;
	logic [7:0]       mark_cnt_q;
	logic             out_valid_q;
	srrw_pkg::out_t   out_q;

	logic             ram_we;
	logic [ABITS-1:0] ram_waddr;
	logic             ram_wdata;
	logic             ram_rdata;
	logic [33:0]      base34;
	logic [33:0]      ws34;
	logic [33:0]      seq34;
	logic [33:0]      room;
	logic [33:0]      off;
	logic [33:0]      pe_lo;
	logic             out_free;
	logic             accepted;

	assign base34   = 34'(base_q);
	assign ws34     = 34'(ws_q);
	assign seq34    = 34'(seq_q);
	assign room     = BUF34 - base34;
	assign off      = base34 + (pstart_q - ws34);
	assign pe_lo    = (sum_q < ws34) ? ws34 : sum_q;
	assign out_free = !out_valid_q || out_ready;
	assign accepted = pend_q > pstart_q;

	assign ctl.pop      = (state_q == ST_IDLE) && head.valid;
	assign ctl.clearing = (state_q == ST_CLEAR);
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

	// Map write port: clearing pass or byte marking.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = mark_addr_q;
		ram_wdata = epoch_q;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = 1'b0;
		end else if (state_q == ST_MARK) begin
			ram_we = 1'b1;
		end
	end

	// A map bit counts as received when it equals the current epoch.
	srrw_ram #(.WIDTH(1), .DEPTH(BUFFER_BYTES)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (base_q[ABITS-1:0]),
		.rdata (ram_rdata)
	);

	// Datapath registers, loaded along the sequence.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				seq_q <= head.item.seq_start;
				len_q <= head.item.payload_len;
			end
			ST_C1: begin
				ws_q <= origin_q + 32'(base_q);
				wl_q <= (34'(window_bytes) < room) ? 34'(window_bytes) : room;
			end
			ST_C2: begin
				pstart_q <= (seq_q > ws_q) ? seq34 : ws34;
				sum_q    <= seq34 + 34'(len_q);
				wsend_q  <= ws34 + wl_q;
			end
			ST_C3: begin
				pend_q <= (pe_lo > wsend_q) ? wsend_q : pe_lo;
				pswl_q <= pstart_q + wl_q;
			end
			ST_C4: begin
				if (pend_q > pswl_q) begin
					pend_q <= pswl_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Result register contents.
	always_ff @(posedge clk) begin
		if (state_q == ST_RES && out_free) begin
			out_q.flushed     <= flushed_q;
			out_q.stream_base <= ws_q;
			out_q.done_res    <= ws_q >= file_bytes;
			if (accepted) begin
				out_q.verdict       <= srrw_pkg::VERDICT_ACCEPT;
				out_q.buffer_offset <= off[15:0];
				out_q.packet_offset <= 8'(pstart_q - seq34);
				out_q.write_len     <= 8'(pend_q - pstart_q);
				out_q.ack_pos       <= seq_q;
				out_q.ack_len       <= 8'(pend_q - seq34);
			end else if (sum_q <= ws34) begin
				out_q.verdict       <= srrw_pkg::VERDICT_DUPLICATE;
				out_q.buffer_offset <= 16'd0;
				out_q.packet_offset <= 8'd0;
				out_q.write_len     <= 8'd0;
				out_q.ack_pos       <= seq_q;
				out_q.ack_len       <= len_q;
			end else begin
				out_q.verdict       <= srrw_pkg::VERDICT_IGNORE;
				out_q.buffer_offset <= 16'd0;
				out_q.packet_offset <= 8'd0;
				out_q.write_len     <= 8'd0;
				out_q.ack_pos       <= 32'd0;
				out_q.ack_len       <= 8'd0;
			end
		end
	end

	// Result valid flag: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RES && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			epoch_q     <= 1'b1;
			base_q      <= '0;
			origin_q    <= 32'd0;
			flushed_q   <= 1'b0;
			mark_addr_q <= '0;
			mark_cnt_q  <= 8'd0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ABITS'(1);
					if (32'(clr_addr_q) == 32'(BUFFER_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					flushed_q <= 1'b0;
					if (head.valid) begin
						state_q <= ST_ADVRD;
					end
				end
				ST_ADVRD: begin
					if (34'(base_q) == BUF34) begin
						// Full buffer: release it and start a new epoch.
						base_q    <= '0;
						epoch_q   <= !epoch_q;
						origin_q  <= origin_q + 32'(BUFFER_BYTES);
						flushed_q <= 1'b1;
						state_q   <= ST_C1;
					end else begin
						state_q <= ST_ADVCK;
					end
				end
				ST_ADVCK: begin
					if (ram_rdata == epoch_q) begin
						base_q  <= base_q + (ABITS+1)'(1);
						state_q <= ST_ADVRD;
					end else begin
						state_q <= ST_C1;
					end
				end
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_C3;
				ST_C3: state_q <= ST_C4;
				ST_C4: state_q <= ST_RES;
				ST_RES: begin
					if (out_free) begin
						mark_addr_q <= off[ABITS-1:0];
						mark_cnt_q  <= 8'(pend_q - pstart_q);
						state_q     <= accepted ? ST_MARK : ST_IDLE;
					end
				end
				ST_MARK: begin
					mark_addr_q <= mark_addr_q + ABITS'(1);
					mark_cnt_q  <= mark_cnt_q - 8'd1;
					if (mark_cnt_q == 8'd1) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The base never runs past the end of the buffer.
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		34'(base_q) <= BUF34) else $error("base beyond buffer");
	// A release returns the base to the buffer start.
	a_flush_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADVRD && 34'(base_q) == BUF34) |=> base_q == '0)
		else $error("base not reset on release");
	// Marking always has bytes left to write.
	a_mark_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MARK |-> mark_cnt_q != 8'd0) else $error("empty mark run");
	// A result is only loaded while the register is free.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RES && out_valid_q && !out_ready) |=> state_q == ST_RES)
		else $error("result overwritten");

endmodule

[rtl/core/selective_repeat_rx_window.sv]
// ----------------------------------------------------------------------------
// selective_repeat_rx_window
// Byte-granular selective-repeat receive window with a received-byte map.
//
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_ready  | in_data   (srrw_pkg::in_t)
// out     | out | out_valid/out_ready| out_data  (srrw_pkg::out_t)
// cfg     | in  | cfg_we             | cfg_index, cfg_wdata
//
// A request passes through the idle state, a map read and check for each byte
// the base advances over, a final map check (skipped when the buffer is
// released), four clipping states and the result state, which waits for a free
// result register, then marks each accepted byte in the map, one at a time.
// After reset a clearing pass over every map address runs before any request
// is taken; configuration writes are taken during it.
// A two-entry queue takes requests while the back end works or waits on out.
// ----------------------------------------------------------------------------
module selective_repeat_rx_window #(
	parameter int BUFFER_BYTES = 65536,
	parameter int MAX_PAYLOAD  = 250
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  srrw_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output srrw_pkg::out_t                  out_data,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [srrw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic [16:0]           window_q;
	logic [31:0]           file_q;
	srrw_pkg::queue_head_t head;
	srrw_pkg::back_ctl_t   ctl;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= srrw_pkg::WINDOW_RESET;
			file_q   <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				srrw_pkg::CFG_WINDOW_BYTES: window_q <= cfg_wdata[16:0];
				srrw_pkg::CFG_FILE_BYTES:   file_q   <= cfg_wdata[31:0];
				default: begin
				end
			endcase
		end
	end

	srrw_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.ctl      (ctl),
		.head     (head)
	);

	srrw_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.ctl          (ctl),
		.window_bytes (window_q),
		.file_bytes   (file_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the selective-repeat receive window against an in-bench predictor
// of the byte map, the in-order base and the flush. Packet headers go
// through a queue-fed driver and results are compared in a clocked monitor.
// Both sides idle in random bursts except in the last phase.
// ----------------------------------------------------------------------------
module testbench;

	localparam int BUF_SIZE    = 65536;
	localparam int PAYLOAD_MAX = 250;
	localparam int STALL_LIMIT = 400000;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	srrw_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	srrw_pkg::out_t out_data;
	logic           cfg_we;
	logic           cfg_index;
	logic [31:0]    cfg_wdata;

	selective_repeat_rx_window dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor state: received-byte map, in-order base, stream origin, registers.
	bit          rx_map [0:BUF_SIZE-1];
	int          win_base;
	logic [31:0] origin_pos;
	logic [16:0] win_size;
	logic [31:0] file_size;

	srrw_pkg::in_t  header_q [$];
	srrw_pkg::out_t verdict_q [$];
	int   errors;
	bit   idle_on;
	int   in_gap;
	int   out_gap;
	int   quiet_cycles;
	logic [31:0] gen_pos;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", field, got, want);
		errors++;
	endtask

	// Works out the result of one packet header and updates the map.
	function automatic srrw_pkg::out_t predict_window(srrw_pkg::in_t hdr);
		longint unsigned seq, len, ws, room, wl, pstart, pend, off;
		srrw_pkg::out_t r;
		r = '0;
		seq = hdr.seq_start;
		len = hdr.payload_len;
		if (len > PAYLOAD_MAX) len = PAYLOAD_MAX;
		// Advance the base over received bytes, then flush a full buffer.
		while (win_base < BUF_SIZE && rx_map[win_base]) win_base++;
		if (win_base >= BUF_SIZE) begin
			foreach (rx_map[k]) rx_map[k] = 1'b0;
			win_base = 0;
			origin_pos = origin_pos + 32'(BUF_SIZE);
			r.flushed = 1'b1;
		end
		ws = 64'(origin_pos + 32'(win_base));
		room = BUF_SIZE - win_base;
		wl = (win_size < room) ? win_size : room;
		// Clip the packet to the window.
		pstart = (seq > ws) ? seq : ws;
		pend = seq + len;
		if (pend < ws) pend = ws;
		if (pend > ws + wl) pend = ws + wl;
		if (pend > pstart + wl) pend = pstart + wl;
		if (pend > pstart) begin
			off = win_base + (pstart - ws);
			for (longint unsigned k = 0; k < pend - pstart; k++)
				if (off + k < BUF_SIZE) rx_map[off + k] = 1'b1;
			r.verdict = srrw_pkg::VERDICT_ACCEPT;
			r.buffer_offset = off[15:0];
			r.packet_offset = 8'(pstart - seq);
			r.write_len = 8'(pend - pstart);
			r.ack_pos = seq[31:0];
			r.ack_len = 8'(pend - seq);
		end else if (seq + len <= ws) begin
			r.verdict = srrw_pkg::VERDICT_DUPLICATE;
			r.ack_pos = seq[31:0];
			r.ack_len = len[7:0];
		end else begin
			r.verdict = srrw_pkg::VERDICT_IGNORE;
		end
		r.stream_base = ws[31:0];
		r.done_res = (ws >= file_size);
		return r;
	endfunction

	// Driver: holds a request until taken, idles in bursts.
	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_gap = 0;
		end else begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				verdict_q.push_back(predict_window(in_data));
				next_valid = 1'b0;
			end
			if (!(in_valid && !in_ready)) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (header_q.size() > 0) begin
					if (idle_on && $urandom_range(0, 9) == 0) begin
						in_gap = $urandom_range(1, 12) - 1;
					end else begin
						in_data <= header_q.pop_front();
						next_valid = 1'b1;
					end
				end
			end
			in_valid <= next_valid;
		end
	end

	// Monitor: compares each result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		srrw_pkg::out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("unexpected result", out_data.stream_base, 32'd0);
				end else begin
					want = verdict_q.pop_front();
					if (out_data.verdict !== want.verdict)
						report_mismatch("verdict", 32'(out_data.verdict), 32'(want.verdict));
					if (out_data.buffer_offset !== want.buffer_offset)
						report_mismatch("buffer_offset", 32'(out_data.buffer_offset),
							32'(want.buffer_offset));
					if (out_data.packet_offset !== want.packet_offset)
						report_mismatch("packet_offset", 32'(out_data.packet_offset),
							32'(want.packet_offset));
					if (out_data.write_len !== want.write_len)
						report_mismatch("write_len", 32'(out_data.write_len), 32'(want.write_len));
					if (out_data.ack_pos !== want.ack_pos)
						report_mismatch("ack_pos", out_data.ack_pos, want.ack_pos);
					if (out_data.ack_len !== want.ack_len)
						report_mismatch("ack_len", 32'(out_data.ack_len), 32'(want.ack_len));
					if (out_data.flushed !== want.flushed)
						report_mismatch("flushed", 32'(out_data.flushed), 32'(want.flushed));
					if (out_data.stream_base !== want.stream_base)
						report_mismatch("stream_base", out_data.stream_base, want.stream_base);
					if (out_data.done_res !== want.done_res)
						report_mismatch("done_res", 32'(out_data.done_res), 32'(want.done_res));
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_gap = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: counts cycles with work pending and nothing accepted.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
			(header_q.size() == 0 && !in_valid && verdict_q.size() == 0)) begin
			quiet_cycles = 0;
		end else if (++quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL selective_repeat_rx_window");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx == srrw_pkg::CFG_WINDOW_BYTES) win_size = value[16:0];
		else file_size = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every request is answered and the byte marking has finished.
	task automatic wait_idle();
		while (header_q.size() > 0 || in_valid || verdict_q.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic void push_header(logic [31:0] seq, logic [7:0] len);
		srrw_pkg::in_t h;
		h.seq_start = seq;
		h.payload_len = len;
		header_q.push_back(h);
	endfunction

	// Mostly in-order packets, some out of order or repeated, the rest noise.
	function automatic void push_random(int count);
		int pick;
		logic [7:0] len;
		gen_pos = origin_pos + 32'(win_base);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			len = (pick % 7 == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 250));
			if (pick < 75) begin
				push_header(gen_pos, len);
				gen_pos = gen_pos + ((len > PAYLOAD_MAX) ? PAYLOAD_MAX : len);
			end else if (pick < 84) begin
				push_header(gen_pos + $urandom_range(1, 2000), len);
			end else if (pick < 93) begin
				push_header(gen_pos - $urandom_range(0, 3000), len);
			end else begin
				push_header($urandom(), 8'($urandom()));
			end
		end
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = srrw_pkg::CFG_WINDOW_BYTES;
		cfg_wdata = '0;
		foreach (rx_map[k]) rx_map[k] = 1'b0;
		win_base = 0;
		origin_pos = '0;
		win_size = srrw_pkg::WINDOW_RESET;
		file_size = '0;
		errors = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed packets under the reset configuration.
		push_header(32'd0, 8'd0);
		push_header(32'd0, 8'd250);
		push_header(32'd250, 8'd255);
		push_header(32'd100, 8'd50);
		push_header(32'd600, 8'd10);
		push_header(32'd2000, 8'd10);
		push_header(32'd1740, 8'd250);
		push_header(32'hFFFF_FFFF, 8'd250);
		push_header(32'hFFFF_FF06, 8'd250);
		push_header(32'd500, 8'd100);
		push_header(32'd5, 8'd0);
		push_header(32'd3000, 8'd0);
		push_header(32'd400, 8'd200);
		wait_idle();

		// Empty window, then a one-byte window.
		write_reg(srrw_pkg::CFG_WINDOW_BYTES, 32'd0);
		write_reg(srrw_pkg::CFG_FILE_BYTES, 32'hFFFF_FFFF);
		push_random(10);
		wait_idle();
		write_reg(srrw_pkg::CFG_WINDOW_BYTES, 32'd1);
		write_reg(srrw_pkg::CFG_FILE_BYTES, 32'd0);
		push_random(20);
		wait_idle();

		// Full window with a long run of random packets.
		write_reg(srrw_pkg::CFG_WINDOW_BYTES, 32'd65536);
		write_reg(srrw_pkg::CFG_FILE_BYTES, 32'd40000);
		push_random(650);
		wait_idle();

		// Last part without idling on either side.
		write_reg(srrw_pkg::CFG_WINDOW_BYTES, 32'd1250);
		write_reg(srrw_pkg::CFG_FILE_BYTES, $urandom_range(0, 90000));
		idle_on = 1'b0;
		push_random(350);
		wait_idle();

		if (errors == 0) begin
			$display("PASS selective_repeat_rx_window");
		end else begin
			$display("FAIL selective_repeat_rx_window");
		end
		$finish;
	end

endmodule

[selective_repeat_rx_window.f]
rtl/core/srrw_pkg.sv
rtl/core/srrw_ram.sv
rtl/core/srrw_front.sv
rtl/core/srrw_back.sv
rtl/core/selective_repeat_rx_window.sv
sim/testbench.sv
